// ===== hdl/wfcm_pkg.sv =====
// shared types, constants and codes of the wall follow corner mapper
`default_nettype none

package wfcm_pkg;

    localparam int WINDOW_LEN_DEF  = 20;
    localparam int MAX_CORNERS_DEF = 16;

    localparam int NEAR_LIMIT  = 500;
    localparam int CLOSE_LIMIT = 12;
    localparam int CLOSE_BASE  = 100;

    localparam logic [2:0]  STATE_DONE = 3'd6;
    localparam logic [15:0] RUN_MAX    = 16'hFFFF;

    localparam logic [7:0]  TARGET_RST = 8'd20;
    localparam logic [11:0] RADIUS_RST = 12'd16;
    localparam logic [7:0]  SPEED_RST  = 8'd40;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 2'd2;

    // divider geometry, fixed by the position sums and the run length
    localparam int DIV_W  = 32;
    localparam int DIV_DW = 16;
    localparam int DIV_SW = 6;

    // quotient bits for each division
    localparam logic [DIV_SW-1:0] STEPS_AVG = 6'd32;
    localparam logic [DIV_SW-1:0] STEPS_PT  = 6'd18;

    // x / 20 as (x * 3277) >> 16, exact for x below 16384
    localparam logic [11:0] CAP_RECIP = 12'd3277;
    localparam int          CAP_SHIFT = 16;

    // target states of the behaviour
    localparam logic [3:0] TGT_RETURN = 4'd1;
    localparam logic [3:0] TGT_LEFT   = 4'd2;
    localparam logic [3:0] TGT_RIGHT  = 4'd3;
    localparam logic [3:0] TGT_HOLD   = 4'd5;
    localparam logic [3:0] TGT_DONE   = 4'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WIN,
        ST_DXS,
        ST_DXW,
        ST_DYS,
        ST_DYW,
        ST_STORE,
        ST_RD,
        ST_CMP,
        ST_CTL,
        ST_PTS,
        ST_PTW,
        ST_OUT
    } t_seq_state;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_DW-1:0] divisor;
        logic [DIV_SW-1:0] steps;
    } t_div_req;

endpackage

`default_nettype wire

// ===== hdl/wfcm_ifs.sv =====
// channel interfaces: input tick, result and configuration write
`default_nettype none

interface wfcm_item_if;
    logic              valid;
    logic              ready;
    logic [2:0]        state_code;
    logic [7:0]        center_sensor;
    logic [7:0]        left_sensor;
    logic [7:0]        right_sensor;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;

    modport source (output valid, state_code, center_sensor, left_sensor, right_sensor,
                    pos_x, pos_y, input ready);
    modport sink (input valid, state_code, center_sensor, left_sensor, right_sensor,
                  pos_x, pos_y, output ready);
endinterface

interface wfcm_result_if;
    logic              valid;
    logic              ready;
    logic signed [3:0] state_offset;
    logic [7:0]        left_motor_bias;
    logic [7:0]        right_motor_bias;

    modport source (output valid, state_offset, left_motor_bias, right_motor_bias,
                    input ready);
    modport sink (input valid, state_offset, left_motor_bias, right_motor_bias,
                  output ready);
endinterface

interface wfcm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [11:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/wall_follow_corner_mapper.sv =====
// wall follow corner mapper: window scoring, corner store, p-control sequencer
//
// i_item carries one control tick (state code, three proximity readings,
// position); i_cfg writes target distance (0), match radius (1), cruise
// speed (2), other indexes are ignored; o_result carries the state offset
// and two motor biases. a tick with state code 6 gives no result.
// one tick at a time: i_item.ready is high only while the sequencer idles.
// a tick that closes no corner passes the window and control steps and, while
// the collision flag is set and the target is nonzero, one 18-bit pass of
// the shared divider for the p-term, before it loads the output register;
// the sequencer is idle again for the next tick once that register loads.
// a closing corner adds two 32-bit divider passes for the averages, the store
// and a read and compare step for each stored corner that is compared.
// the result sits in an output register; a new tick is taken while it
// waits, and the sequencer holds before loading the next result until the
// receiver has taken the old one.
// reset is synchronous active low: window head and sum, counts, sums and flags clear,
// config returns to 20, 16, 40. the corner store holds no reset value.
`default_nettype none

module wall_follow_corner_mapper
    import wfcm_pkg::*;
#(
    parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
    parameter int MAX_CORNERS = MAX_CORNERS_DEF
)
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    wfcm_item_if.sink     i_item,
    wfcm_cfg_if.sink      i_cfg,
    wfcm_result_if.source o_result
);

    localparam int HW    = $clog2(WINDOW_LEN);
    localparam int TOT_W = $clog2(WINDOW_LEN * CLOSE_BASE + 1);
    localparam int IW    = $clog2(MAX_CORNERS);
    localparam int CW    = $clog2(MAX_CORNERS + 1);

    t_seq_state r_state, n_state;

    // configuration
    logic [7:0]  r_target;
    logic [11:0] r_radius;
    logic [7:0]  r_speed;

    // latched tick
    logic [2:0]         r_st;
    logic [7:0]         r_cs, r_ls, r_rs;
    logic signed [15:0] r_px, r_py;

    // closeness window
    logic [6:0]       r_win [WINDOW_LEN];
    logic [6:0]       r_win_rd;
    logic [HW-1:0]    r_head;
    logic             r_wrapped;
    logic [TOT_W-1:0] r_wsum;

    // corner run and store
    logic signed [31:0] r_sum_x, r_sum_y;
    logic [15:0]        r_run;
    logic signed [15:0] r_ax, r_ay;
    logic signed [15:0] r_cx [MAX_CORNERS];
    logic signed [15:0] r_cy [MAX_CORNERS];
    logic signed [15:0] r_cx_rd, r_cy_rd;
    logic [CW-1:0]      r_ctot;
    logic [IW-1:0]      r_idx;

    // flags
    logic r_prev_near, r_finished, r_collided, r_hold, r_short;

    // control terms
    logic [15:0] r_prod;
    logic [7:0]  r_cap, r_pterm;

    // result register
    logic              r_out_vld;
    logic signed [3:0] r_o_offset;
    logic [7:0]        r_o_lmb, r_o_rmb;

    // divider
    t_div_req         div_req;
    logic             div_done;
    logic [DIV_W-1:0] div_quot;

    logic             item_fire, out_fire, out_free;
    logic [6:0]       new_val, old_val;
    logic [TOT_W-1:0] wsum_n;
    logic             near;
    logic             closing;
    logic [CW-1:0]    ctot_inc;
    logic [IW-1:0]    slot;
    logic [16:0]      dx, dy, adx, ady;
    logic             match;
    logic             coll_n;
    logic [7:0]       err;
    logic [12:0]      cap_num;
    logic [24:0]      cap_prod;
    logic [7:0]       cap_q;
    logic [10:0]      pt_den;
    logic [31:0]      sum_x_abs, sum_y_abs;
    logic [15:0]      run_div;
    logic [15:0]      avg_mag;
    logic [7:0]       drive;
    logic signed [3:0] off_n;
    logic [7:0]       lmb_n, rmb_n;
    logic             hold_clr;

    function automatic logic signed [3:0] offset_of(input logic [3:0] tgt, input logic [2:0] st);
        offset_of = tgt - {1'b0, st};
    endfunction

    wfcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign item_fire = i_item.valid && i_item.ready;
    assign out_fire  = r_out_vld && o_result.ready;
    assign out_free  = !r_out_vld || o_result.ready;

    assign i_item.ready = (r_state == ST_IDLE);
    assign i_cfg.ready  = 1'b1;

    assign o_result.valid            = r_out_vld;
    assign o_result.state_offset     = r_o_offset;
    assign o_result.left_motor_bias  = r_o_lmb;
    assign o_result.right_motor_bias = r_o_rmb;

    // window arithmetic
    assign new_val = (r_cs < 8'(CLOSE_LIMIT) && r_rs < 8'(CLOSE_LIMIT))
                   ? 7'(8'(CLOSE_BASE) - r_cs - r_rs) : 7'd0;
    assign old_val = r_wrapped ? r_win_rd : 7'd0;
    assign wsum_n  = r_wsum - TOT_W'(old_val) + TOT_W'(new_val);
    assign near    = (32'(wsum_n) >= 32'(NEAR_LIMIT));
    assign closing = r_prev_near && !near;

    // corner arithmetic
    assign sum_x_abs = r_sum_x[31] ? 32'(-r_sum_x) : 32'(r_sum_x);
    assign sum_y_abs = r_sum_y[31] ? 32'(-r_sum_y) : 32'(r_sum_y);
    assign run_div   = (r_run == 16'd0) ? 16'd1 : r_run;
    assign avg_mag   = div_quot[15:0];
    assign ctot_inc  = (32'(r_ctot) < 32'(MAX_CORNERS)) ? r_ctot + 1'b1 : r_ctot;
    assign slot      = (32'(r_ctot) < 32'(MAX_CORNERS)) ? r_ctot[IW-1:0] : IW'(MAX_CORNERS - 1);
    assign dx        = {r_cx_rd[15], r_cx_rd} - {r_ax[15], r_ax};
    assign dy        = {r_cy_rd[15], r_cy_rd} - {r_ay[15], r_ay};
    assign adx       = dx[16] ? 17'(-dx) : dx;
    assign ady       = dy[16] ? 17'(-dy) : dy;
    assign match     = (adx < {5'd0, r_radius}) && (ady < {5'd0, r_radius});

    // control arithmetic
    assign coll_n   = r_collided || (r_st > 3'd1);
    assign err      = (r_rs > r_target) ? r_rs - r_target : r_target - r_rs;
    assign cap_num  = {1'b0, r_speed, 4'd0} + {4'd0, r_speed, 1'b0} + {5'd0, r_speed};
    // speed cap floor(19s/20) by reciprocal multiply
    assign cap_prod = {12'd0, cap_num} * {13'd0, CAP_RECIP};
    assign cap_q    = cap_prod[CAP_SHIFT +: 8];
    assign pt_den   = {1'b0, r_target, 2'd0} + {3'd0, r_target};
    assign drive    = r_speed - r_pterm;

    always_comb begin
        off_n    = '0;
        lmb_n    = '0;
        rmb_n    = '0;
        hold_clr = 1'b0;
        if (r_short) begin
            off_n = offset_of(TGT_RETURN, r_st);
        end else begin
            if (r_collided) begin
                if (r_rs < r_target) begin
                    off_n = offset_of(TGT_LEFT, r_st);
                    lmb_n = drive;
                end else begin
                    off_n = offset_of(TGT_RIGHT, r_st);
                    rmb_n = drive;
                end
            end
            if (r_hold) begin
                if (r_rs < r_ls) begin
                    hold_clr = 1'b1;
                    off_n    = offset_of(TGT_RIGHT, r_st);
                    rmb_n    = r_speed;
                end else begin
                    off_n = offset_of(TGT_HOLD, r_st);
                end
            end
            if (r_finished) begin
                off_n = offset_of(TGT_DONE, r_st);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (item_fire && i_item.state_code != STATE_DONE) n_state = ST_WIN;
            end
            ST_WIN:   n_state = closing ? ST_DXS : ST_CTL;
            ST_DXS:   n_state = ST_DXW;
            ST_DXW:   if (div_done) n_state = ST_DYS;
            ST_DYS:   n_state = ST_DYW;
            ST_DYW:   if (div_done) n_state = ST_STORE;
            ST_STORE: n_state = (32'(ctot_inc) < 32'd2) ? ST_CTL : ST_RD;
            ST_RD:    n_state = ST_CMP;
            ST_CMP: begin
                if (match) begin
                    n_state = (r_idx < IW'(2) && 32'(r_ctot) < 32'd3) ? ST_OUT : ST_CTL;
                end else if (32'(r_idx) + 32'd2 < 32'(r_ctot)) begin
                    n_state = ST_RD;
                end else begin
                    n_state = ST_CTL;
                end
            end
            ST_CTL:   n_state = (coll_n && r_target != 8'd0) ? ST_PTS : ST_OUT;
            ST_PTS:   n_state = ST_PTW;
            ST_PTW:   if (div_done) n_state = ST_OUT;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // divider requests
    always_comb begin
        div_req = '0;
        case (r_state)
            ST_DXS: begin
                div_req.start    = 1'b1;
                div_req.dividend = sum_x_abs;
                div_req.divisor  = run_div;
                div_req.steps    = STEPS_AVG;
            end
            ST_DYS: begin
                div_req.start    = 1'b1;
                div_req.dividend = sum_y_abs;
                div_req.divisor  = run_div;
                div_req.steps    = STEPS_AVG;
            end
            ST_PTS: begin
                div_req.start    = 1'b1;
                div_req.dividend = {r_prod, 2'd0, 14'd0};
                div_req.divisor  = {5'd0, pt_den};
                div_req.steps    = STEPS_PT;
            end
            default: div_req = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RST;
            r_radius <= RADIUS_RST;
            r_speed  <= SPEED_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_TARGET: r_target <= i_cfg.data[7:0];
                CFG_RADIUS: r_radius <= i_cfg.data;
                CFG_SPEED:  r_speed  <= i_cfg.data[7:0];
                default:    ;
            endcase
        end
    end

    // tick payload
    always_ff @(posedge i_clk) begin
        if (item_fire) begin
            r_st <= i_item.state_code;
            r_cs <= i_item.center_sensor;
            r_ls <= i_item.left_sensor;
            r_rs <= i_item.right_sensor;
            r_px <= i_item.pos_x;
            r_py <= i_item.pos_y;
        end
    end

    // window memory
    always_ff @(posedge i_clk) begin
        if (r_state == ST_WIN) r_win[r_head] <= new_val;
        r_win_rd <= r_win[r_head];
    end

    // corner store
    always_ff @(posedge i_clk) begin
        if (r_state == ST_STORE) begin
            r_cx[slot] <= r_ax;
            r_cy[slot] <= r_ay;
        end
        r_cx_rd <= r_cx[r_idx];
        r_cy_rd <= r_cy[r_idx];
    end

    // control state of the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_wrapped   <= 1'b0;
            r_wsum      <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_run       <= '0;
            r_ctot      <= '0;
            r_idx       <= '0;
            r_prev_near <= 1'b0;
            r_finished  <= 1'b0;
            r_collided  <= 1'b0;
            r_hold      <= 1'b0;
            r_short     <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (r_state == ST_OUT && out_free) r_out_vld <= 1'b1;
            else if (out_fire)                 r_out_vld <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (item_fire) r_short <= 1'b0;
                end
                ST_WIN: begin
                    r_wsum      <= wsum_n;
                    r_prev_near <= near;
                    if (r_head == HW'(WINDOW_LEN - 1)) begin
                        r_head    <= '0;
                        r_wrapped <= 1'b1;
                    end else begin
                        r_head <= r_head + 1'b1;
                    end
                    if (!r_prev_near && near) begin
                        r_sum_x <= 32'(r_px);
                        r_sum_y <= 32'(r_py);
                        r_run   <= 16'd1;
                    end else if (r_prev_near && near && r_run != RUN_MAX) begin
                        r_sum_x <= r_sum_x + 32'(r_px);
                        r_sum_y <= r_sum_y + 32'(r_py);
                        r_run   <= r_run + 1'b1;
                    end
                end
                ST_STORE: begin
                    r_ctot  <= ctot_inc;
                    r_sum_x <= '0;
                    r_sum_y <= '0;
                    r_run   <= '0;
                    r_idx   <= '0;
                end
                ST_CMP: begin
                    if (match) begin
                        if (r_idx < IW'(2)) begin
                            if (32'(r_ctot) > 32'd3) r_finished <= 1'b1;
                            if (32'(r_ctot) < 32'd3) begin
                                r_short    <= 1'b1;
                                r_collided <= 1'b0;
                            end
                        end else begin
                            r_ctot <= r_ctot - 1'b1;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_CTL: begin
                    if (r_st > 3'd1 && !r_collided && r_ls < r_rs) r_hold <= 1'b1;
                    r_collided <= coll_n;
                end
                ST_OUT: begin
                    if (out_free && hold_clr) r_hold <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_DXW: if (div_done) r_ax <= r_sum_x[31] ? 16'(-avg_mag) : avg_mag;
            ST_DYW: if (div_done) r_ay <= r_sum_y[31] ? 16'(-avg_mag) : avg_mag;
            ST_CTL: begin
                r_prod  <= {8'd0, r_speed} * {8'd0, err};
                r_cap   <= cap_q;
                r_pterm <= cap_q;
            end
            ST_PTW: begin
                if (div_done) begin
                    r_pterm <= (div_quot > 32'(r_cap)) ? r_cap : div_quot[7:0];
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    r_o_offset <= off_n;
                    r_o_lmb    <= lmb_n;
                    r_o_rmb    <= rmb_n;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/wfcm_div.sv =====
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module wfcm_div
    import wfcm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_div_req         i_req,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_SW-1:0] r_cnt;
    logic [DIV_W-1:0]  r_acc;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_dvs;
    logic [DIV_DW:0]   trial;
    logic              ge;

    // dividend is left aligned so the quotient ends in the low bits
    assign trial = {r_rem, r_acc[DIV_W-1]};
    assign ge    = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? DIV_DW'(trial - {1'b0, r_dvs}) : trial[DIV_DW-1:0];
            r_acc <= {r_acc[DIV_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_acc;

endmodule

`default_nettype wire
